/* design/itoa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CharW   = 7;
  localparam int unsigned NibW    = 4;
  localparam int unsigned CntW    = 5;
  localparam int unsigned BcdNibs = 10;

  localparam logic [1:0] MODE_DEC = 2'd0;
  localparam logic [1:0] MODE_HEX = 2'd1;

  localparam logic [CntW-1:0] DABBLE_LAST = 5'd31;
  localparam logic [CntW-1:0] FULL_LEN    = 5'd16;

  localparam logic [CharW-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CharW-1:0] CHAR_X     = 7'h78;
  localparam logic [CharW-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CharW-1:0] CHAR_A     = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_PFX_ZERO,
    ST_PFX_X,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } itoa_state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ZERO,
    EMIT_X,
    EMIT_MINUS,
    EMIT_DIGIT
  } itoa_emit_t;

  typedef struct packed {
    logic       load;
    logic       dabble;
    logic       shift;
    itoa_emit_t emit;
  } itoa_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic cnt_one;
    logic dabble_last;
    logic neg;
  } itoa_sts_t;

  function automatic logic [CharW-1:0] hex_char(input logic [NibW-1:0] nib);
    logic [CharW-1:0] n7;
    n7 = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_char = CHAR_ZERO + n7;
    end else begin
      hex_char = CHAR_A + n7 - 7'd10;
    end
  endfunction

endpackage
`default_nettype wire

/* design/integer_to_ascii_converter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_converter
// Prints one number as ASCII text, one character per output beat.
// ----------------------------------------------------------------------------
// Input: a beat is taken on the clock edge where start is high and busy is
// low. in_mode 0 gives signed decimal of in_value[31:0], 1 signed hex without
// leading zeros, 2 and 3 "0x" plus 16 hex digits of all 64 bits.
// Output: each character shows for one cycle with out_valid high, most
// significant first; out_last marks the final one. The receiver cannot stall.
// Sequence: modes 2/3 give back-to-back characters, the first registered
// from the state entered on the accepting edge. Mode 1 spends a sign step,
// a skip step per leading zero (8 to 15) plus one, then 1 to 8 digits.
// Mode 0 first runs a shift-add-3 binary to BCD pass over the 32-bit
// magnitude, then sign, skip and 1 to 10 digits. busy drops as the last
// character is registered, so the next number is taken while that beat is
// on the port.
// Reset: synchronous, active low; returns to idle with no beat pending.
// ----------------------------------------------------------------------------
module integer_to_ascii_converter
  import itoa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_mode,
  input  wire logic [ValueW-1:0] in_value,
  output logic                   out_valid,
  output logic [CharW-1:0]       out_character,
  output logic                   out_last
);

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  itoa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after start");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("idle while text incomplete");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("beat straight after last character");
`endif

endmodule
`default_nettype wire

/* design/itoa_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: digit buffer, binary to BCD shift-add-3 unit, digit counter and
// the registered character output.
// ----------------------------------------------------------------------------
module itoa_dp
  import itoa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        in_mode,
  input  wire logic [ValueW-1:0] in_value,
  input  itoa_cmd_t              cmd,
  output itoa_sts_t              sts,
  output logic                   out_valid,
  output logic [CharW-1:0]       out_character,
  output logic                   out_last
);

  logic [ValueW-1:0] digits_r, digits_nxt;
  logic [WordW-1:0]  bin_r, bin_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic              valid_r, valid_nxt;
  logic [CharW-1:0]  char_r, char_nxt;
  logic              last_r, last_nxt;

  logic [WordW-1:0]  word;
  logic [WordW-1:0]  mag;
  logic [ValueW-1:0] adj;
  logic [NibW-1:0]   top_nib;

  assign word    = in_value[WordW-1:0];
  assign mag     = word[WordW-1] ? (WordW'(0) - word) : word;
  assign top_nib = digits_r[ValueW-1 -: NibW];

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    adj = digits_r;
    for (int i = 0; i < BcdNibs; i++) begin
      if (digits_r[i*NibW +: NibW] >= 4'd5) begin
        adj[i*NibW +: NibW] = digits_r[i*NibW +: NibW] + 4'd3;
      end
    end
  end

  always_comb begin
    digits_nxt = digits_r;
    bin_nxt    = bin_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    if (cmd.load) begin
      neg_nxt = word[WordW-1];
      bin_nxt = mag;
      case (in_mode)
        MODE_DEC: begin
          digits_nxt = '0;
          cnt_nxt    = '0;
        end
        MODE_HEX: begin
          digits_nxt = {{(ValueW-WordW){1'b0}}, mag};
          cnt_nxt    = FULL_LEN;
        end
        default: begin
          digits_nxt = in_value;
          cnt_nxt    = FULL_LEN;
        end
      endcase
    end else if (cmd.dabble) begin
      digits_nxt = {adj[ValueW-2:0], bin_r[WordW-1]};
      bin_nxt    = {bin_r[WordW-2:0], 1'b0};
      cnt_nxt    = (cnt_r == DABBLE_LAST) ? FULL_LEN : cnt_r + 5'd1;
    end else if (cmd.shift) begin
      digits_nxt = {digits_r[ValueW-NibW-1:0], {NibW{1'b0}}};
      cnt_nxt    = cnt_r - 5'd1;
    end
  end

  always_comb begin
    valid_nxt = 1'b1;
    last_nxt  = 1'b0;
    case (cmd.emit)
      EMIT_ZERO:  char_nxt = CHAR_ZERO;
      EMIT_X:     char_nxt = CHAR_X;
      EMIT_MINUS: char_nxt = CHAR_MINUS;
      EMIT_DIGIT: begin
        char_nxt = hex_char(top_nib);
        last_nxt = (cnt_r == 5'd1);
      end
      default: begin
        valid_nxt = 1'b0;
        char_nxt  = char_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
    bin_r    <= bin_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign sts.top_zero    = (top_nib == '0);
  assign sts.cnt_one     = (cnt_r == 5'd1);
  assign sts.dabble_last = (cnt_r == DABBLE_LAST);
  assign sts.neg         = neg_r;

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule
`default_nettype wire

/* design/itoa_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_ctrl
// Controller: sequences load, BCD conversion, prefix, sign, leading-zero
// skip and digit output.
// ----------------------------------------------------------------------------
module itoa_ctrl
  import itoa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_mode,
  input  itoa_sts_t       sts,
  output itoa_cmd_t       cmd,
  output logic            busy
);

  itoa_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_mode)
            MODE_DEC: state_nxt = ST_CONVERT;
            MODE_HEX: state_nxt = ST_SIGN;
            default:  state_nxt = ST_PFX_ZERO;
          endcase
        end
      end
      ST_CONVERT:  if (sts.dabble_last) state_nxt = ST_SIGN;
      ST_PFX_ZERO: state_nxt = ST_PFX_X;
      ST_PFX_X:    state_nxt = ST_EMIT;
      ST_SIGN:     state_nxt = ST_SKIP;
      ST_SKIP:     if (!sts.top_zero || sts.cnt_one) state_nxt = ST_EMIT;
      ST_EMIT:     if (sts.cnt_one) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '{load: 1'b0, dabble: 1'b0, shift: 1'b0, emit: EMIT_NONE};
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONVERT:  cmd.dabble = 1'b1;
      ST_PFX_ZERO: cmd.emit = EMIT_ZERO;
      ST_PFX_X:    cmd.emit = EMIT_X;
      ST_SIGN:     if (sts.neg) cmd.emit = EMIT_MINUS;
      ST_SKIP:     cmd.shift = sts.top_zero && !sts.cnt_one;
      ST_EMIT: begin
        cmd.emit  = EMIT_DIGIT;
        cmd.shift = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire
